// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion forms for the squelch calibration checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property once reset is released
`define NFAS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("noise floor squelch check failed");

// check a property at every edge, reset included
`define NFAS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("noise floor squelch check failed");

`endif

// ----- src/nfas_pkg.sv -----
// ----------------------------------------------------------------------------
// nfas_pkg
// Types and constants of the noise floor auto squelch calibration block.
// ----------------------------------------------------------------------------
package nfas_pkg;

    // sweep store
    localparam int MAX_SAMPLES = 24;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int MARGIN_W = 7;
    localparam int SQ_W     = 7;
    localparam int USED_W   = 5;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = SAMPLE_W + 1;

    // calibration constants
    localparam logic [CNT_W-1:0]    MIN_SAMPLES  = CNT_W'(3);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(6);
    localparam logic [SQ_W-1:0]     SQUELCH_MIN  = SQ_W'(1);
    localparam logic [SQ_W-1:0]     SQUELCH_MAX  = SQ_W'(100);

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SIGNAL = 2'd2;

    // control state
    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_CALC
    } nfas_state_t;

    // insertion request broadcast along the cell row
    typedef struct packed {
        logic                en;
        logic [SAMPLE_W-1:0] data;
    } nfas_ins_t;

endpackage

// ----- src/nfas_cell.sv -----
// ----------------------------------------------------------------------------
// nfas_cell
// One slot of the sorted sample row: keeps its value or takes the new item
// or its left neighbor's value so the row stays in ascending order.
// ----------------------------------------------------------------------------
module nfas_cell import nfas_pkg::*; (
    input  logic                aclk,
    input  nfas_ins_t           ins,       // insertion request
    input  logic                used,      // slot holds a sample of this sweep
    input  logic                left_lt,   // new item sorts before left slot
    input  logic [SAMPLE_W-1:0] left_val,  // left slot value
    output logic                lt,        // new item sorts before this slot
    output logic [SAMPLE_W-1:0] val        // slot value
);

    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;

    // an empty slot sorts after everything
    assign lt  = !used || (ins.data < val_reg);
    assign val = val_reg;

    // shift right from the left neighbor or take the new item
    always_comb begin
        val_next = val_reg;
        if (ins.en && lt) begin
            if (left_lt) begin
                val_next = left_val;
            end else begin
                val_next = ins.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

// ----- src/nfas_chain.sv -----
// ----------------------------------------------------------------------------
// nfas_chain
// Row of sort cells; each insertion moves larger values one slot right.
// ----------------------------------------------------------------------------
module nfas_chain import nfas_pkg::*; (
    input  logic                aclk,
    input  nfas_ins_t           ins,
    input  logic [CNT_W-1:0]    count,
    output logic [SAMPLE_W-1:0] vals [MAX_SAMPLES]
);

    logic lt_row [MAX_SAMPLES];

    // first cell has nothing to its left
    nfas_cell u_cell_0 (
        .aclk     (aclk),
        .ins      (ins),
        .used     (count != '0),
        .left_lt  (1'b0),
        .left_val ('0),
        .lt       (lt_row[0]),
        .val      (vals[0])
    );

    // remaining cells take from their left neighbor
    for (genvar i = 1; i < MAX_SAMPLES; i++) begin : g_cell
        nfas_cell u_cell (
            .aclk     (aclk),
            .ins      (ins),
            .used     (CNT_W'(i) < count),
            .left_lt  (lt_row[i-1]),
            .left_val (vals[i-1]),
            .lt       (lt_row[i]),
            .val      (vals[i])
        );
    end

endmodule

// ----- src/noise_floor_auto_squelch_unit.sv -----
// The item marked last moves the unit to the calculation state, which registers
// the result once the output register is free. Samples are taken one per cycle
// while collecting; s_tready is low throughout the calculation state.
// Each accepted sample that fits is sorted into the cell row in that cycle.
// Reset: synchronous active low; clears sample count, state, output valid
// and sets the margin to 6.
// ----------------------------------------------------------------------------
// noise_floor_auto_squelch_unit
// Collects a sweep of peak samples in a sorted cell row; after the last item
// it reports the median noise floor and squelch level, or a failure status.
// ----------------------------------------------------------------------------
module noise_floor_auto_squelch_unit import nfas_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [MARGIN_W-1:0] cfg_wr_data,  // squelch_margin
    // sample input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,      // [7:0] peak_sample
    input  logic                s_tlast,      // last_sample
    // calibration result
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,      // [7:0] floor_level,
                                              // [14:8] squelch_level,
                                              // [19:15] samples_used, rest 0
    output logic [1:0]          m_tuser       // [1:0] calib_status
);

    nfas_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                nz_reg, nz_next;
    logic [MARGIN_W-1:0] margin_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SAMPLE_W-1:0] floor_reg, floor_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [USED_W-1:0]   used_reg, used_next;

    nfas_ins_t           ins;
    logic [SAMPLE_W-1:0] vals [MAX_SAMPLES];
    logic                accept;
    logic [IDX_W-1:0]    med_idx;
    logic [SAMPLE_W-1:0] med_val;
    logic [SUM_W-1:0]    sum;

    assign s_tready = (state_reg == ST_COLLECT);
    assign accept   = s_tvalid && s_tready;

    // store only while there is room
    assign ins.en   = accept && (count_reg < CNT_W'(MAX_SAMPLES));
    assign ins.data = s_tdata;

    nfas_chain u_chain (
        .aclk  (aclk),
        .ins   (ins),
        .count (count_reg),
        .vals  (vals)
    );

    // median pick and margin add
    assign med_idx = IDX_W'(count_reg >> 1);
    assign med_val = vals[med_idx];
    assign sum     = SUM_W'(med_val) + SUM_W'(margin_reg);

    // sequencing and result formation
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        nz_next        = nz_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        floor_next     = floor_reg;
        sq_next        = sq_reg;
        used_next      = used_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT: begin
                if (ins.en) begin
                    count_next = count_reg + CNT_W'(1);
                    nz_next    = nz_reg || (s_tdata != '0);
                end
                if (accept && s_tlast) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    used_next      = USED_W'(count_reg);
                    floor_next     = '0;
                    sq_next        = '0;
                    if (count_reg < MIN_SAMPLES) begin
                        status_next = STATUS_TOO_FEW;
                    end else if (!nz_reg) begin
                        status_next = STATUS_NO_SIGNAL;
                    end else begin
                        status_next = STATUS_OK;
                        floor_next  = med_val;
                        if (sum == '0) begin
                            sq_next = SQUELCH_MIN;
                        end else if (sum > SUM_W'(SQUELCH_MAX)) begin
                            sq_next = SQUELCH_MAX;
                        end else begin
                            sq_next = SQ_W'(sum);
                        end
                    end
                    count_next = '0;
                    nz_next    = 1'b0;
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            nz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            nz_reg        <= nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // margin register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
        end else if (cfg_wr_en) begin
            margin_reg <= cfg_wr_data;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        floor_reg  <= floor_next;
        sq_reg     <= sq_next;
        used_reg   <= used_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0, used_reg, sq_reg, floor_reg};

endmodule

// ----- src/nfas_checker.sv -----
// ----------------------------------------------------------------------------
// nfas_checker
// Port-level checks of the noise floor auto squelch unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfas_checker import nfas_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [23:0]         m_tdata,
    input logic [1:0]          m_tuser
);

    logic [SQ_W-1:0]   sq_lvl;
    logic [USED_W-1:0] used_cnt;
    logic [25:0]       m_item;
    logic              sq_ok;
    logic              enough_used;

    // result fields
    assign sq_lvl      = m_tdata[14:8];
    assign used_cnt    = m_tdata[19:15];
    assign m_item      = {m_tuser, m_tdata};
    assign sq_ok       = (sq_lvl != '0) && (sq_lvl <= SQUELCH_MAX);
    assign enough_used = (used_cnt >= USED_W'(MIN_SAMPLES));

    // a stalled result holds
    `NFAS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_item))

    // reset drops the result
    `NFAS_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid)

    // a good calibration gives a squelch in range from enough samples
    `NFAS_ASSERT(a_ok, aclk, aresetn, m_tvalid && m_tuser == STATUS_OK |-> sq_ok && enough_used)

    // a failed calibration reports zero floor and squelch
    `NFAS_ASSERT(a_fail, aclk, aresetn, m_tvalid && m_tuser != STATUS_OK |-> m_tdata[14:0] == '0)

    // too few is reported only for short sweeps
    `NFAS_ASSERT(a_few, aclk, aresetn, m_tvalid && m_tuser == STATUS_TOO_FEW |-> !enough_used)

endmodule

bind noise_floor_auto_squelch_unit nfas_checker u_nfas_checker (.*);

// ----- sim/noise_floor_auto_squelch_unit_tb.sv -----
// ----------------------------------------------------------------------------
// noise_floor_auto_squelch_unit_tb
// Sends sweeps of peak samples into the squelch calibration block and checks
// every reported result. Each result is compared with a local model that
// keeps its own sweep store and margin, and works out the floor from a
// histogram of the kept samples. The run covers several margin settings,
// short sweeps, sweeps longer than the store, random idling on both sides
// and one long receiver stall.
// ----------------------------------------------------------------------------
module noise_floor_auto_squelch_unit_tb;
    import nfas_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 180;
    localparam int NUM_PHASES    = 6;

    // one input item of a sweep
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic                last;
    } sweep_item_t;

    // one calibration result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SAMPLE_W-1:0] floor_lvl;
        logic [SQ_W-1:0]     squelch;
        logic [USED_W-1:0]   used;
    } calib_result_t;

    // content styles for random sweeps
    typedef enum int {
        FILL_WIDE,
        FILL_LOW,
        FILL_ZERO,
        FILL_SPARSE
    } sweep_fill_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [MARGIN_W-1:0] cfg_wr_data = MARGIN_RESET;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = '0;
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [23:0]         m_tdata;
    logic [1:0]          m_tuser;

    // stimulus and prediction state
    sweep_item_t         pending_items[$];
    calib_result_t       calib_expected[$];
    logic [SAMPLE_W-1:0] sweep_peaks[$];
    logic [MARGIN_W-1:0] margin_setting = MARGIN_RESET;
    int                  queued_count   = 0;
    int                  accepted_count = 0;
    int                  error_count    = 0;
    int                  cycle_count    = 0;
    bit                  idle_on        = 1'b1;
    logic                hold_req       = 1'b0;

    // driver and ready process temporaries
    sweep_item_t         next_item;
    logic                next_valid;
    int                  src_gap   = 0;
    int                  sink_gap  = 0;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    calib_result_t       got_result;
    calib_result_t       want_result;

    noise_floor_auto_squelch_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // keep a sample of the sweep and, on the last item, form the expected result
    task automatic collect_peak(input logic [SAMPLE_W-1:0] peak, input logic last);
        int            hist [256];
        int            n;
        int            seen;
        int            rank;
        int            sum;
        int            v;
        calib_result_t r;
        if (sweep_peaks.size() < MAX_SAMPLES) begin
            sweep_peaks.push_back(peak);
        end
        if (last) begin
            n = sweep_peaks.size();
            r = '0;
            r.used = USED_W'(n);
            for (v = 0; v < 256; v++) begin
                hist[v] = 0;
            end
            foreach (sweep_peaks[i]) begin
                hist[sweep_peaks[i]]++;
            end
            if (n < MIN_SAMPLES) begin
                r.status = STATUS_TOO_FEW;
            end else if (hist[0] == n) begin
                r.status = STATUS_NO_SIGNAL;
            end else begin
                r.status = STATUS_OK;
                // walk the histogram up to the middle rank
                rank = n / 2;
                seen = 0;
                for (v = 0; v < 256; v++) begin
                    if (seen <= rank && seen + hist[v] > rank) begin
                        r.floor_lvl = SAMPLE_W'(v);
                    end
                    seen += hist[v];
                end
                sum = int'(r.floor_lvl) + int'(margin_setting);
                if (sum < int'(SQUELCH_MIN)) begin
                    sum = int'(SQUELCH_MIN);
                end
                if (sum > int'(SQUELCH_MAX)) begin
                    sum = int'(SQUELCH_MAX);
                end
                r.squelch = SQ_W'(sum);
            end
            calib_expected.push_back(r);
            sweep_peaks.delete();
        end
    endtask

    task automatic queue_peak(input int peak, input bit last);
        sweep_item_t it;
        it.peak = SAMPLE_W'(peak);
        it.last = last;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // one sweep of random length and content
    task automatic add_random_sweep(input bit short_only);
        int          len;
        int          pick;
        int          i;
        int          peak;
        sweep_fill_t fill;
        pick = $urandom_range(0, 19);
        if (short_only) begin
            len = $urandom_range(1, 5);
        end else if (pick == 0) begin
            len = $urandom_range(1, 2);
        end else if (pick <= 2) begin
            len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
        end else if (pick <= 4) begin
            len = $urandom_range(3, 5);
        end else begin
            len = $urandom_range(3, MAX_SAMPLES);
        end
        fill = sweep_fill_t'($urandom_range(0, 3));
        for (i = 0; i < len; i++) begin
            case (fill)
                FILL_WIDE:   peak = $urandom_range(0, 255);
                FILL_LOW:    peak = $urandom_range(0, 12);
                FILL_ZERO:   peak = 0;
                default:     peak = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : 0;
            endcase
            queue_peak(peak, i == len - 1);
        end
    endtask

    // wait until every item is taken and every result is back, then let it settle
    task automatic wait_drained();
        while (accepted_count != queued_count || calib_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_margin(input logic [MARGIN_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        margin_setting = value;
    endtask

    // sample driver fed from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                collect_peak(s_tdata, s_tlast);
                accepted_count++;
                next_valid = 1'b0;
                if (idle_on && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(1, 6);
                end
            end
            if (!next_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_tdata   <= next_item.peak;
                    s_tlast   <= next_item.last;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // result ready with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
            hold_left = 0;
        end else begin
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    sink_gap = $urandom_range(1, 6);
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status    = m_tuser;
            got_result.floor_lvl = m_tdata[7:0];
            got_result.squelch   = m_tdata[14:8];
            got_result.used      = m_tdata[19:15];
            if (calib_expected.size() == 0) begin
                $error("result with no sweep pending: status %0d floor %0d squelch %0d used %0d",
                       got_result.status, got_result.floor_lvl, got_result.squelch,
                       got_result.used);
                error_count++;
            end else begin
                want_result = calib_expected.pop_front();
                if (got_result.status !== want_result.status) begin
                    $error("calib_status expected %0d got %0d",
                           want_result.status, got_result.status);
                    error_count++;
                end
                if (got_result.floor_lvl !== want_result.floor_lvl) begin
                    $error("floor_level expected %0d got %0d",
                           want_result.floor_lvl, got_result.floor_lvl);
                    error_count++;
                end
                if (got_result.squelch !== want_result.squelch) begin
                    $error("squelch_level expected %0d got %0d",
                           want_result.squelch, got_result.squelch);
                    error_count++;
                end
                if (got_result.used !== want_result.used) begin
                    $error("samples_used expected %0d got %0d",
                           want_result.used, got_result.used);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int phase;
        int phase_start;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset margin: too few, all zero, clamp high, even count, zero floor
        queue_peak(255, 1);
        queue_peak(0, 0);
        queue_peak(128, 1);
        queue_peak(0, 0);
        queue_peak(0, 0);
        queue_peak(0, 1);
        queue_peak(200, 0);
        queue_peak(255, 0);
        queue_peak(100, 1);
        queue_peak(4, 0);
        queue_peak(1, 0);
        queue_peak(3, 0);
        queue_peak(2, 1);
        queue_peak(0, 0);
        queue_peak(0, 0);
        queue_peak(5, 1);
        wait_drained();

        // zero margin: squelch clamped up to the minimum, then no clamp
        write_margin('0);
        queue_peak(0, 0);
        queue_peak(0, 0);
        queue_peak(7, 1);
        queue_peak(94, 0);
        queue_peak(94, 0);
        queue_peak(94, 1);
        wait_drained();

        // largest margin on a tiny floor
        write_margin(MARGIN_W'(127));
        queue_peak(0, 0);
        queue_peak(1, 0);
        queue_peak(0, 1);
        wait_drained();

        // random sweeps under several margins
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_margin(MARGIN_W'(127));
                1: write_margin(MARGIN_W'(100));
                4: write_margin('0);
                5: write_margin(MARGIN_RESET);
                default: write_margin(MARGIN_W'($urandom_range(0, 127)));
            endcase
            if (phase == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            phase_start = queued_count;
            if (phase == 0) begin
                // overflow sweep whose last item is dropped
                for (int i = 0; i < MAX_SAMPLES + 6; i++) begin
                    queue_peak($urandom_range(0, 255), i == MAX_SAMPLES + 5);
                end
            end
            if (phase == 1) begin
                // long receiver stall while short sweeps keep coming
                hold_req <= 1'b1;
            end
            while (queued_count - phase_start < PHASE_ITEMS) begin
                add_random_sweep(phase == 1);
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
